@@ hw/rtl/pvd_pkg.sv @@
package pvd_pkg;

	localparam int DEF_MAX_CONTOUR_LENGTH = 4096;
	localparam int DEF_SAMPLE_WIDTH = 16;

	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS_DELTA = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPORT_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_CONTOUR = 2'd2;

	localparam int HYSTERESIS_RESET = 8;
	localparam int THRESHOLD_RESET = 16;

endpackage

@@ hw/rtl/pvd_cfg_regs.sv @@
module pvd_cfg_regs #(
	parameter int SAMPLE_WIDTH = pvd_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pvd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [SAMPLE_WIDTH-2:0]          cfg_data,
	output logic [SAMPLE_WIDTH-2:0]          hysteresis_delta_q,
	output logic [SAMPLE_WIDTH-2:0]          report_threshold_q,
	output logic                             closed_contour_q
);
	import pvd_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hysteresis_delta_q <= (SAMPLE_WIDTH-1)'(HYSTERESIS_RESET);
			report_threshold_q <= (SAMPLE_WIDTH-1)'(THRESHOLD_RESET);
			closed_contour_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HYSTERESIS_DELTA: hysteresis_delta_q <= cfg_data;
				REG_REPORT_THRESHOLD: report_threshold_q <= cfg_data;
				REG_CLOSED_CONTOUR: closed_contour_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/pvd_tracker.sv @@
module pvd_tracker #(
	parameter int MAX_CONTOUR_LENGTH = pvd_pkg::DEF_MAX_CONTOUR_LENGTH,
	parameter int SAMPLE_WIDTH = pvd_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  step,
	input  logic signed [SAMPLE_WIDTH-1:0]        val,
	input  logic [$clog2(MAX_CONTOUR_LENGTH)-1:0] pos_in,
	input  logic                                  start,
	input  logic                                  last,
	input  logic [SAMPLE_WIDTH-2:0]               hysteresis_delta,
	input  logic [SAMPLE_WIDTH-2:0]               report_threshold,
	input  logic                                  closed,
	output logic                                  hit,
	output logic                                  hit_is_min,
	output logic [$clog2(MAX_CONTOUR_LENGTH)-1:0] hit_pos,
	output logic signed [SAMPLE_WIDTH-1:0]        hit_value
);
	localparam int POS_W = $clog2(MAX_CONTOUR_LENGTH);
	localparam int SW = SAMPLE_WIDTH;

	logic signed [SW-1:0] max_q, min_q;
	logic [POS_W-1:0]     max_pos_q, min_pos_q;
	logic                 seek_q, second_pass_q;

	logic [POS_W-1:0]     pos;
	logic signed [SW-1:0] cur_max, cur_min, new_max, new_min;
	logic [POS_W-1:0]     cur_max_pos, cur_min_pos, new_max_pos, new_min_pos;
	logic                 seek, sp, may_report, confirm;
	logic signed [SW:0]   val_x, delta_x, thres_x, max_lim, min_lim;

	always_comb begin
		if ({1'b0, pos_in} >= (POS_W+1)'(MAX_CONTOUR_LENGTH)) begin
			pos = POS_W'({1'b0, pos_in} - (POS_W+1)'(MAX_CONTOUR_LENGTH));
		end else begin
			pos = pos_in;
		end

		cur_max = start ? val : max_q;
		cur_max_pos = start ? pos : max_pos_q;
		cur_min = start ? val : min_q;
		cur_min_pos = start ? pos : min_pos_q;
		seek = start ? 1'b1 : seek_q;
		sp = start ? 1'b0 : second_pass_q;
		may_report = sp || !closed;

		new_max = (val > cur_max) ? val : cur_max;
		new_max_pos = (val > cur_max) ? pos : cur_max_pos;
		new_min = (val < cur_min) ? val : cur_min;
		new_min_pos = (val < cur_min) ? pos : cur_min_pos;

		val_x = {val[SW-1], val};
		delta_x = {2'b00, hysteresis_delta};
		thres_x = {2'b00, report_threshold};
		max_lim = {new_max[SW-1], new_max} - delta_x;
		min_lim = {new_min[SW-1], new_min} + delta_x;

		hit = 1'b0;
		hit_is_min = !seek;
		if (seek) begin
			confirm = val_x < max_lim;
			hit_pos = new_max_pos;
			hit_value = new_max;
			hit = confirm && ($signed({new_max[SW-1], new_max}) > thres_x) && may_report
				&& !(!closed && new_max_pos == '0);
		end else begin
			confirm = val_x > min_lim;
			hit_pos = new_min_pos;
			hit_value = new_min;
			hit = confirm && ($signed({new_min[SW-1], new_min}) < -thres_x) && may_report
				&& !(!closed && new_min_pos == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= {1'b1, {(SW-1){1'b0}}};
			max_pos_q <= '0;
			min_q <= {1'b0, {(SW-1){1'b1}}};
			min_pos_q <= '0;
			seek_q <= 1'b1;
			second_pass_q <= 1'b0;
		end else if (step) begin
			max_q <= (confirm && !seek) ? val : new_max;
			max_pos_q <= (confirm && !seek) ? pos : new_max_pos;
			min_q <= (confirm && seek) ? val : new_min;
			min_pos_q <= (confirm && seek) ? pos : new_min_pos;
			seek_q <= confirm ? !seek : seek;
			second_pass_q <= (last && closed) ? 1'b1 : sp;
		end
	end

	a_min_then_seek_max: assert property (@(posedge clk) disable iff (!arst_n)
		step && hit && hit_is_min |=> seek_q)
		else $error("Tracker is not seeking a maximum after a reported minimum.");

	a_max_then_seek_min: assert property (@(posedge clk) disable iff (!arst_n)
		step && hit && !hit_is_min |=> !seek_q)
		else $error("Tracker is not seeking a minimum after a reported maximum.");

	a_start_clears_pass: assert property (@(posedge clk) disable iff (!arst_n)
		step && start && !(last && closed) |=> !second_pass_q)
		else $error("Second pass flag survived a start of contour.");

	a_max_above_min_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		step && start && !confirm |=> max_q >= min_q)
		else $error("Running maximum fell below running minimum after a start.");

endmodule

@@ hw/rtl/peak_valley_detector.sv @@
// Datapath: an accepted item is held in the input register, and its result, if any,
// is then registered in the result register.
// Throughput: one item per cycle while in_stall is low; the tracker state updates once per item.
// A reporting item waits in the input register only while a held result is stalled;
// an item that yields no result never waits on the output side.
// Reset (arst_n low) sets the trackers, mode and pass flag, loads the register defaults
// and empties both stages at once.
module peak_valley_detector #(
	parameter int MAX_CONTOUR_LENGTH = pvd_pkg::DEF_MAX_CONTOUR_LENGTH,
	parameter int SAMPLE_WIDTH = pvd_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pvd_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [SAMPLE_WIDTH-2:0]               cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]        curvature_sample,
	input  logic [$clog2(MAX_CONTOUR_LENGTH)-1:0] sample_position,
	input  logic                                  start_of_contour,
	input  logic                                  end_of_pass,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [$clog2(MAX_CONTOUR_LENGTH)-1:0] extremum_position,
	output logic                                  extremum_is_minimum,
	output logic signed [SAMPLE_WIDTH-1:0]        extremum_value
);
	import pvd_pkg::*;

	localparam int POS_W = $clog2(MAX_CONTOUR_LENGTH);

	logic [SAMPLE_WIDTH-2:0] hysteresis_delta_q, report_threshold_q;
	logic                    closed_contour_q;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;
	logic [POS_W-1:0]               pos_s1;
	logic                           start_s1, last_s1;

	logic                           res_hit, res_is_min;
	logic [POS_W-1:0]               res_pos;
	logic signed [SAMPLE_WIDTH-1:0] res_value;

	logic out_valid_q, out_free, advance, take;

	pvd_cfg_regs #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.hysteresis_delta_q(hysteresis_delta_q),
		.report_threshold_q(report_threshold_q),
		.closed_contour_q(closed_contour_q)
	);

	pvd_tracker #(
		.MAX_CONTOUR_LENGTH(MAX_CONTOUR_LENGTH),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_tracker (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.val(sample_s1),
		.pos_in(pos_s1),
		.start(start_s1),
		.last(last_s1),
		.hysteresis_delta(hysteresis_delta_q),
		.report_threshold(report_threshold_q),
		.closed(closed_contour_q),
		.hit(res_hit),
		.hit_is_min(res_is_min),
		.hit_pos(res_pos),
		.hit_value(res_value)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign advance = valid_s1 && (out_free || !res_hit);
	assign in_stall = valid_s1 && !advance;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1 <= curvature_sample;
			pos_s1 <= sample_position;
			start_s1 <= start_of_contour;
			last_s1 <= end_of_pass;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res_hit) begin
			extremum_position <= res_pos;
			extremum_is_minimum <= res_is_min;
			extremum_value <= res_value;
		end
	end

	assign out_valid = out_valid_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("Input stalled with an empty input register.");

	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && res_hit))
		else $error("Result appeared without a reporting item.");

	a_held_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("A stalled result was dropped.");

	a_blocked_reporter: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_hit && out_valid_q && out_stall |-> !advance)
		else $error("A reporting item advanced into a full result register.");

endmodule
